>>> hw/rtl/spfp_pkg.sv
// ----------------------------------------------------------------------------
// spfp_pkg: shared types and constants of the sync pair frame parser
// Sync byte, length limits, register indexes and the judged frame record.
// ----------------------------------------------------------------------------
package spfp_pkg;

  localparam int unsigned MaxFrameDefault = 256;
  localparam int unsigned MinFrame        = 16;
  localparam int unsigned GainFracBits    = 14;
  localparam int unsigned PayloadBytes    = 10;

  localparam logic [7:0] SyncByte = 8'h55;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned PwmW     = 19;

  localparam logic [CfgIdxW-1:0] RegPwmOffset = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegPwmGain   = CfgIdxW'(1);

  localparam logic [CfgDataW-1:0] PwmOffsetReset = 16'd1100;
  localparam logic [CfgDataW-1:0] PwmGainReset   = 16'd21845;

  // One judged frame: verdict plus frame offsets 4..13
  typedef struct packed {
    logic                         good;
    logic [PayloadBytes-1:0][7:0] payload;
  } frame_evt_t;

endpackage

>>> hw/rtl/sync_pair_frame_parser_xor_top.sv
// ----------------------------------------------------------------------------
// sync_pair_frame_parser_xor_top: serial frame parser with XOR checksum
// Splits a byte stream at 0x55 0x55 pairs, checks each frame and drives pwm.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  in       | in_valid_i/in_ready_o  | rx_byte_i
//  out      | out_valid_o/out_ready_i| frame_good_o, pwm_*_o, *_color_o,
//           |                        | good_frames_o, bad_frames_o
//  cfg      | cfg_we_i (no wait)     | cfg_idx_i, cfg_wdata_i
//
// One byte is taken per cycle while in_ready_o is high. A frame verdict
// leaves the parser through a one-beat event register in the cycle after the
// closing sync byte is taken, and the scaled pwm values (one 16x16 multiply
// per lane) then land in the result register once it is free to take them.
// Reset clears sync state, held outputs and counters; config regs reload
// their defaults. A stalled output backs up into the event register; the
// input stalls only when both are full.
// ----------------------------------------------------------------------------
module sync_pair_frame_parser_xor_top #(
  parameter int unsigned MAX_FRAME = spfp_pkg::MaxFrameDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // byte input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    rx_byte_i,
  // frame results
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          frame_good_o,
  output logic [spfp_pkg::PwmW-1:0]     pwm_one_o,
  output logic [spfp_pkg::PwmW-1:0]     pwm_two_o,
  output logic [spfp_pkg::PwmW-1:0]     pwm_three_o,
  output logic [spfp_pkg::PwmW-1:0]     pwm_four_o,
  output logic [7:0]                    head_color_o,
  output logic [7:0]                    tail_color_o,
  output logic [31:0]                   good_frames_o,
  output logic [31:0]                   bad_frames_o,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [spfp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [spfp_pkg::CfgDataW-1:0] cfg_wdata_i
);

  logic [spfp_pkg::CfgDataW-1:0]  pwm_offset_q;
  logic [spfp_pkg::CfgDataW-1:0]  pwm_gain_q;
  logic                           evt_valid;
  logic                           evt_take;
  spfp_pkg::frame_evt_t           evt;
  logic                           beat;
  logic [3:0][spfp_pkg::PwmW-1:0] pwm;

  // Config registers; writes to unused indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_offset_q <= spfp_pkg::PwmOffsetReset;
      pwm_gain_q   <= spfp_pkg::PwmGainReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        spfp_pkg::RegPwmOffset: pwm_offset_q <= cfg_wdata_i;
        spfp_pkg::RegPwmGain:   pwm_gain_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Take a byte whenever the event slot is empty or draining this cycle
  assign in_ready_o = !evt_valid || evt_take;
  assign beat       = in_valid_i && in_ready_o;

  spfp_parser #(
    .MAX_FRAME (MAX_FRAME)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .rx_byte_i   (rx_byte_i),
    .evt_valid_o (evt_valid),
    .evt_o       (evt),
    .evt_take_i  (evt_take)
  );

  spfp_result u_result (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .evt_valid_i   (evt_valid),
    .evt_i         (evt),
    .evt_take_o    (evt_take),
    .pwm_offset_i  (pwm_offset_q),
    .pwm_gain_i    (pwm_gain_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .frame_good_o  (frame_good_o),
    .pwm_o         (pwm),
    .head_color_o  (head_color_o),
    .tail_color_o  (tail_color_o),
    .good_frames_o (good_frames_o),
    .bad_frames_o  (bad_frames_o)
  );

  assign pwm_one_o   = pwm[0];
  assign pwm_two_o   = pwm[1];
  assign pwm_three_o = pwm[2];
  assign pwm_four_o  = pwm[3];

endmodule

>>> hw/rtl/spfp_parser.sv
// ----------------------------------------------------------------------------
// spfp_parser: byte stream framing and checksum tracking
// Finds 0x55 0x55 starts, tracks position, XOR and payload, judges frames.
// ----------------------------------------------------------------------------
module spfp_parser #(
  parameter int unsigned MAX_FRAME = spfp_pkg::MaxFrameDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    beat_i,
  input  logic [7:0]              rx_byte_i,
  output logic                    evt_valid_o,
  output spfp_pkg::frame_evt_t    evt_o,
  input  logic                    evt_take_i
);

  localparam int unsigned PosW = $clog2(MAX_FRAME + 3);
  localparam logic [PosW-1:0] PosSat   = PosW'(MAX_FRAME + 2);
  localparam logic [PosW-1:0] PosStart = PosW'(2);
  localparam logic [PosW-1:0] PosMin   = PosW'(spfp_pkg::MinFrame + 1);
  localparam logic [PosW-1:0] PosMax   = PosW'(MAX_FRAME + 1);
  localparam logic [PosW-1:0] PosXor   = PosW'(5);

  logic                  synced_q;
  logic [PosW-1:0]       pos_q;
  logic [7:0]            xor_q;
  logic [2:0][7:0]       recent_q;
  logic [spfp_pkg::PayloadBytes-1:0][7:0] cap_q;
  logic                  evt_valid_q;
  spfp_pkg::frame_evt_t  evt_q;

  logic pair;
  logic good;

  assign pair = (rx_byte_i == spfp_pkg::SyncByte) && (recent_q[0] == spfp_pkg::SyncByte);
  assign good = (pos_q >= PosMin) && (pos_q <= PosMax) && (xor_q == recent_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      synced_q    <= 1'b0;
      pos_q       <= '0;
      xor_q       <= '0;
      recent_q    <= '0;
      evt_valid_q <= 1'b0;
    end else begin
      if (evt_take_i) begin
        evt_valid_q <= 1'b0;
      end
      if (beat_i) begin
        recent_q <= {recent_q[1:0], rx_byte_i};
        if (pair) begin
          if (synced_q) begin
            evt_valid_q <= 1'b1;
          end
          synced_q <= 1'b1;
          pos_q    <= PosStart;
          xor_q    <= '0;
        end else if (synced_q) begin
          if (pos_q >= PosXor) begin
            xor_q <= xor_q ^ recent_q[2];
          end
          if (pos_q < PosSat) begin
            pos_q <= pos_q + PosW'(1);
          end
        end
      end
    end
  end

  // Payload capture and frame snapshot: data only, no reset
  always_ff @(posedge clk_i) begin
    if (beat_i) begin
      if (pair && synced_q) begin
        evt_q.good    <= good;
        evt_q.payload <= cap_q;
      end
      if (!pair && synced_q) begin
        for (int i = 0; i < spfp_pkg::PayloadBytes; i++) begin
          if (pos_q == PosW'(i + 4)) begin
            cap_q[i] <= rx_byte_i;
          end
        end
      end
    end
  end

  assign evt_valid_o = evt_valid_q;
  assign evt_o       = evt_q;

endmodule

>>> hw/rtl/spfp_result.sv
// ----------------------------------------------------------------------------
// spfp_result: pwm scaling, held outputs and frame counters
// Scales motor words on a good frame and registers the result beat.
// ----------------------------------------------------------------------------
module spfp_result (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              evt_valid_i,
  input  spfp_pkg::frame_evt_t              evt_i,
  output logic                              evt_take_o,
  input  logic [spfp_pkg::CfgDataW-1:0]     pwm_offset_i,
  input  logic [spfp_pkg::CfgDataW-1:0]     pwm_gain_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              frame_good_o,
  output logic [3:0][spfp_pkg::PwmW-1:0]    pwm_o,
  output logic [7:0]                        head_color_o,
  output logic [7:0]                        tail_color_o,
  output logic [31:0]                       good_frames_o,
  output logic [31:0]                       bad_frames_o
);

  localparam int unsigned ScaledW = 32 - spfp_pkg::GainFracBits;

  logic                           out_valid_q;
  logic                           good_q;
  logic [3:0][spfp_pkg::PwmW-1:0] pwm_q;
  logic [3:0][spfp_pkg::PwmW-1:0] pwm_d;
  logic [7:0]                     head_q;
  logic [7:0]                     tail_q;
  logic [31:0]                    good_cnt_q;
  logic [31:0]                    bad_cnt_q;
  logic                           load;

  assign evt_take_o = evt_valid_i && (!out_valid_q || out_ready_i);
  assign load       = evt_take_o;

  always_comb begin
    logic [15:0]        motor;
    logic [31:0]        prod;
    logic [ScaledW-1:0] scaled;
    for (int l = 0; l < 4; l++) begin
      motor    = {evt_i.payload[2*l+1], evt_i.payload[2*l]};
      prod     = 32'(motor) * 32'(pwm_gain_i);
      scaled   = prod[31:spfp_pkg::GainFracBits];
      pwm_d[l] = spfp_pkg::PwmW'(scaled) + spfp_pkg::PwmW'(pwm_offset_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      good_q      <= 1'b0;
      pwm_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      good_cnt_q  <= '0;
      bad_cnt_q   <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        good_q      <= evt_i.good;
        if (evt_i.good) begin
          pwm_q      <= pwm_d;
          head_q     <= evt_i.payload[8];
          tail_q     <= evt_i.payload[9];
          good_cnt_q <= good_cnt_q + 32'd1;
        end else begin
          bad_cnt_q <= bad_cnt_q + 32'd1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign frame_good_o  = good_q;
  assign pwm_o         = pwm_q;
  assign head_color_o  = head_q;
  assign tail_color_o  = tail_q;
  assign good_frames_o = good_cnt_q;
  assign bad_frames_o  = bad_cnt_q;

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the sync pair frame parser
// Feeds byte streams cut into 0x55 0x55 frames, predicts every frame verdict
// with its held pwm, colors and counters, and checks each result beat.
// ----------------------------------------------------------------------------
module tb;

  // Register index outside the map: the block must ignore writes to it
  localparam logic [spfp_pkg::CfgIdxW-1:0]  RegSpare   = spfp_pkg::CfgIdxW'(2);
  localparam logic [spfp_pkg::CfgDataW-1:0] GainUnity  = 16'h4000;
  localparam int unsigned                   LongHold   = 200;
  localparam int unsigned                   DrainWait  = 8;
  localparam int unsigned                   CycleLimit = 400000;
  localparam int unsigned                   MaxLog     = 40;

  // One result beat: verdict plus held outputs after the judgement
  typedef struct packed {
    logic                           good;
    logic [3:0][spfp_pkg::PwmW-1:0] pwm;
    logic [7:0]                     head;
    logic [7:0]                     tail;
    logic [31:0]                    good_cnt;
    logic [31:0]                    bad_cnt;
  } frame_result_t;

  // Tracks the parser byte by byte and holds the verdicts still to come
  class frame_checker;
    logic [spfp_pkg::CfgDataW-1:0] pwm_offset;
    logic [spfp_pkg::CfgDataW-1:0] pwm_gain;
    bit                            synced;
    int unsigned                   frame_pos;
    logic [7:0]                    run_xor;
    logic [7:0]                    recent[3];
    logic [7:0]                    payload[spfp_pkg::PayloadBytes];
    logic [spfp_pkg::PwmW-1:0]     held_pwm[4];
    logic [7:0]                    held_head;
    logic [7:0]                    held_tail;
    logic [31:0]                   good_cnt;
    logic [31:0]                   bad_cnt;
    frame_result_t                 pending_verdicts[$];
    int unsigned                   bytes_seen;
    int unsigned                   verdicts_due;
    int unsigned                   verdicts_seen;
    int unsigned                   mismatches;
    string lane_name[4] = '{"pwm_one", "pwm_two", "pwm_three", "pwm_four"};

    function new();
      pwm_offset = spfp_pkg::PwmOffsetReset;
      pwm_gain   = spfp_pkg::PwmGainReset;
      synced     = 1'b0;
      frame_pos  = 0;
      run_xor    = 8'h00;
      foreach (recent[i]) recent[i] = 8'h00;
      foreach (payload[i]) payload[i] = 8'h00;
      foreach (held_pwm[i]) held_pwm[i] = '0;
      held_head  = 8'h00;
      held_tail  = 8'h00;
      good_cnt   = '0;
      bad_cnt    = '0;
    endfunction

    function void set_reg(logic [spfp_pkg::CfgIdxW-1:0] idx,
                          logic [spfp_pkg::CfgDataW-1:0] data);
      if (idx == spfp_pkg::RegPwmOffset) pwm_offset = data;
      else if (idx == spfp_pkg::RegPwmGain) pwm_gain = data;
    endfunction

    function logic [spfp_pkg::PwmW-1:0] motor_to_pwm(logic [15:0] motor);
      logic [31:0] prod;
      prod = motor * pwm_gain;
      return spfp_pkg::PwmW'((prod >> spfp_pkg::GainFracBits) + pwm_offset);
    endfunction

    function void note_byte(logic [7:0] b);
      bit            pair;
      bit            ok;
      int unsigned   len;
      int unsigned   k;
      int            i;
      frame_result_t r;
      bytes_seen++;
      pair = (b == spfp_pkg::SyncByte) && (recent[0] == spfp_pkg::SyncByte);
      if (pair) begin
        if (synced) begin
          len = frame_pos - 1;
          ok  = (len >= spfp_pkg::MinFrame) && (len <= spfp_pkg::MaxFrameDefault) &&
                (run_xor == recent[2]);
          if (ok) begin
            for (i = 0; i < 4; i++)
              held_pwm[i] = motor_to_pwm({payload[2*i+1], payload[2*i]});
            held_head = payload[8];
            held_tail = payload[9];
            good_cnt++;
          end else begin
            bad_cnt++;
          end
          r.good     = ok;
          for (i = 0; i < 4; i++) r.pwm[i] = held_pwm[i];
          r.head     = held_head;
          r.tail     = held_tail;
          r.good_cnt = good_cnt;
          r.bad_cnt  = bad_cnt;
          pending_verdicts.push_back(r);
          verdicts_due++;
        end
        synced    = 1'b1;
        frame_pos = 2;
        run_xor   = 8'h00;
      end else if (synced) begin
        k = frame_pos;
        if (k >= 5) run_xor ^= recent[2];
        if (k >= 4 && k <= 13) payload[k-4] = b;
        if (frame_pos < spfp_pkg::MaxFrameDefault + 2) frame_pos++;
      end
      recent[2] = recent[1];
      recent[1] = recent[0];
      recent[0] = b;
    endfunction

    task report_mismatch(string msg);
      if (mismatches < MaxLog) $display("MISMATCH at verdict %0d: %s", verdicts_seen, msg);
      mismatches++;
    endtask

    task check_verdict(frame_result_t got);
      frame_result_t want;
      int            i;
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("result beat with no verdict due (good=%0b)", got.good));
        return;
      end
      want = pending_verdicts.pop_front();
      verdicts_seen++;
      if (got.good !== want.good)
        report_mismatch($sformatf("frame_good %0b, want %0b", got.good, want.good));
      for (i = 0; i < 4; i++)
        if (got.pwm[i] !== want.pwm[i])
          report_mismatch($sformatf("%s %0d, want %0d", lane_name[i], got.pwm[i], want.pwm[i]));
      if (got.head !== want.head)
        report_mismatch($sformatf("head_color %0h, want %0h", got.head, want.head));
      if (got.tail !== want.tail)
        report_mismatch($sformatf("tail_color %0h, want %0h", got.tail, want.tail));
      if (got.good_cnt !== want.good_cnt)
        report_mismatch($sformatf("good_frames %0d, want %0d", got.good_cnt, want.good_cnt));
      if (got.bad_cnt !== want.bad_cnt)
        report_mismatch($sformatf("bad_frames %0d, want %0d", got.bad_cnt, want.bad_cnt));
    endtask
  endclass

  // Every block input holds a known value from time zero
  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic [7:0]                    rx_byte_i   = 8'h00;
  logic                          out_ready_i = 1'b0;
  logic                          cfg_we_i    = 1'b0;
  logic [spfp_pkg::CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [spfp_pkg::CfgDataW-1:0] cfg_wdata_i = '0;

  logic                          in_ready_o;
  logic                          out_valid_o;
  logic                          frame_good_o;
  logic [spfp_pkg::PwmW-1:0]     pwm_one_o;
  logic [spfp_pkg::PwmW-1:0]     pwm_two_o;
  logic [spfp_pkg::PwmW-1:0]     pwm_three_o;
  logic [spfp_pkg::PwmW-1:0]     pwm_four_o;
  logic [7:0]                    head_color_o;
  logic [7:0]                    tail_color_o;
  logic [31:0]                   good_frames_o;
  logic [31:0]                   bad_frames_o;

  frame_checker  sb;
  frame_result_t seen;

  // Idle odds in percent per beat; zero gives a stretch with no idling
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;

  // The main thread bumps hold_requests; the receiver serves it on its own
  int unsigned hold_requests      = 0;
  int unsigned holds_served       = 0;
  int unsigned hold_left          = 0;
  int unsigned stall_left         = 0;
  int unsigned cycle_cnt          = 0;
  int unsigned input_stall_cycles = 0;

  sync_pair_frame_parser_xor_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .frame_good_o (frame_good_o),
    .pwm_one_o    (pwm_one_o),
    .pwm_two_o    (pwm_two_o),
    .pwm_three_o  (pwm_three_o),
    .pwm_four_o   (pwm_four_o),
    .head_color_o (head_color_o),
    .tail_color_o (tail_color_o),
    .good_frames_o(good_frames_o),
    .bad_frames_o (bad_frames_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned gap_cycles();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 60);
  endfunction

  // Hard stop in case the block hangs
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("tb NOT OK");
      $finish;
    end
  end

  // Receiver: a requested long hold wins, then random stalls, else ready
  always @(posedge clk_i) begin
    if (hold_requests != holds_served) begin
      holds_served <= hold_requests;
      hold_left    <= LongHold;
      out_ready_i  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 99) < rx_idle_pct) stall_left <= gap_cycles();
    end
  end

  // Monitor: sample both channels at the edge where a beat moves
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_byte(rx_byte_i);
      if (in_valid_i && !in_ready_o) input_stall_cycles++;
      if (out_valid_o && out_ready_i) begin
        seen.good     = frame_good_o;
        seen.pwm[0]   = pwm_one_o;
        seen.pwm[1]   = pwm_two_o;
        seen.pwm[2]   = pwm_three_o;
        seen.pwm[3]   = pwm_four_o;
        seen.head     = head_color_o;
        seen.tail     = tail_color_o;
        seen.good_cnt = good_frames_o;
        seen.bad_cnt  = bad_frames_o;
        sb.check_verdict(seen);
      end
    end
  end

  // Offer one byte, maybe after a gap, and hold it until the beat moves
  task automatic send_byte(logic [7:0] value);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat (gap_cycles()) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Send a sync pair and len-2 more bytes; the checksum sits at offset len-2.
  // Content avoids forming a stray pair so the frame stays in one piece.
  task automatic send_frame(int unsigned len, bit bad_sum);
    logic [7:0]  prev;
    logic [7:0]  b;
    logic [7:0]  sum;
    int unsigned k;
    send_byte(spfp_pkg::SyncByte);
    send_byte(spfp_pkg::SyncByte);
    prev = spfp_pkg::SyncByte;
    sum  = 8'h00;
    for (k = 2; k < len; k++) begin
      if (len >= 4 && k == len - 2) begin
        b = bad_sum ? sum ^ 8'(1 << $urandom_range(0, 7)) : sum;
      end else begin
        case ($urandom_range(0, 9))
          0:       b = 8'h00;
          1:       b = 8'hFF;
          default: b = 8'($urandom);
        endcase
        // the last byte must not pair with the next start
        if (b == spfp_pkg::SyncByte && (prev == spfp_pkg::SyncByte || k == len - 1)) b = ~b;
      end
      if (k + 3 <= len) sum ^= b;
      send_byte(b);
      prev = b;
    end
  endtask

  // Mostly well-formed frames, with short, long, corrupt ones and noise
  task automatic send_random_traffic(int unsigned byte_budget, int unsigned min_verdicts);
    int unsigned first_byte;
    int unsigned first_verdict;
    int unsigned pick;
    first_byte    = sb.bytes_seen;
    first_verdict = sb.verdicts_due;
    while (sb.bytes_seen - first_byte < byte_budget ||
           sb.verdicts_due - first_verdict < min_verdicts) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_frame($urandom_range(spfp_pkg::MinFrame, 32), $urandom_range(0, 9) == 0);
      end else if (pick < 80) begin
        send_frame($urandom_range(2, spfp_pkg::MinFrame - 1), $urandom_range(0, 1) == 1);
      end else if (pick < 88) begin
        repeat ($urandom_range(3, 20))
          send_byte(($urandom_range(0, 2) == 0) ? spfp_pkg::SyncByte : 8'($urandom));
      end else if (pick < 95) begin
        send_frame($urandom_range(33, 100), $urandom_range(0, 9) == 0);
      end else begin
        // longest legal frame, one byte too long, and lengths from 250 to 300
        case ($urandom_range(0, 2))
          0:       send_frame(spfp_pkg::MaxFrameDefault, 1'b0);
          1:       send_frame(spfp_pkg::MaxFrameDefault + 1, 1'b0);
          default: send_frame($urandom_range(250, 300), 1'b0);
        endcase
      end
    end
  endtask

  task automatic write_reg(logic [spfp_pkg::CfgIdxW-1:0] idx,
                           logic [spfp_pkg::CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drop valid, let the monitor note the last beat, wait for every verdict,
  // then let the pipeline settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  initial begin
    logic [7:0]  body[12];
    logic [7:0]  csum;
    int unsigned phase;
    int unsigned k;

    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, reset register values.
    // Bytes before the first start are dropped, a lone sync byte included.
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(spfp_pkg::SyncByte);
    send_byte(8'h00);
    // Three sync bytes hold two overlapping starts: a frame of length one
    send_byte(spfp_pkg::SyncByte);
    send_byte(spfp_pkg::SyncByte);
    send_byte(spfp_pkg::SyncByte);
    // Shortest legal frame with full-scale and zero motor words
    body = '{8'hAA, 8'h01, 8'hFF, 8'hFF, 8'h00, 8'h00,
             8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00};
    csum = 8'h00;
    for (k = 0; k < 12; k++) begin
      csum ^= body[k];
      send_byte(body[k]);
    end
    send_byte(csum);
    send_byte(8'h7F);
    send_byte(spfp_pkg::SyncByte);
    send_byte(spfp_pkg::SyncByte);
    wait_drained();

    // Random part, one register setting per phase, extremes first
    for (phase = 1; phase <= 5; phase++) begin
      tx_idle_pct = 25;
      rx_idle_pct = 25;
      case (phase)
        1: begin
          write_reg(spfp_pkg::RegPwmOffset, 16'h0000);
          write_reg(spfp_pkg::RegPwmGain, 16'h0000);
        end
        2: begin
          write_reg(spfp_pkg::RegPwmOffset, 16'hFFFF);
          write_reg(spfp_pkg::RegPwmGain, 16'hFFFF);
        end
        3: begin
          write_reg(RegSpare, 16'($urandom));
          write_reg(spfp_pkg::RegPwmOffset, 16'($urandom));
          write_reg(spfp_pkg::RegPwmGain, GainUnity);
        end
        4: begin
          // no idling on either side in this phase
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          write_reg(spfp_pkg::RegPwmOffset, 16'($urandom));
          write_reg(spfp_pkg::RegPwmGain, 16'($urandom));
        end
        default: begin
          write_reg(spfp_pkg::RegPwmOffset, spfp_pkg::PwmOffsetReset);
          write_reg(spfp_pkg::RegPwmGain, spfp_pkg::PwmGainReset);
        end
      endcase

      if (phase == 2) begin
        // Hold the receiver off and stream sync bytes back to back: each one
        // closes a frame, so the result path fills and the input must stall.
        hold_requests++;
        tx_idle_pct = 0;
        repeat (24) send_byte(spfp_pkg::SyncByte);
        tx_idle_pct = 25;
      end

      send_random_traffic(100, 3);
      // close the last open frame so its verdict lands in this phase
      send_byte(spfp_pkg::SyncByte);
      send_byte(spfp_pkg::SyncByte);
      wait_drained();
    end

    if (sb.pending_verdicts.size() != 0)
      sb.report_mismatch($sformatf("%0d verdicts never arrived", sb.pending_verdicts.size()));

    $display("covered %0d bytes over 6 register settings: %0d good and %0d bad frames",
             sb.bytes_seen, sb.good_cnt, sb.bad_cnt);
    $display("input back-pressure held for %0d cycles, %0d mismatches",
             input_stall_cycles, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
